### sv/tmhs_pkg.sv
// ----------------------------------------------------------------------------
// tmhs_pkg
// Types and codes used by the timer heap scheduler top.
// ----------------------------------------------------------------------------
`default_nettype none

package tmhs_pkg;

  localparam int unsigned IdW       = 4;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned NumIds    = 16;
  localparam int unsigned MaxReport = 16;
  localparam int unsigned RepW      = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_RESET  = 2'd2,
    OP_CHECK  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_OK       = 3'd0,
    KIND_REFUSED  = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_EXPIRED  = 3'd3,
    KIND_NONE     = 3'd4,
    KIND_RSVD5    = 3'd5,
    KIND_RSVD6    = 3'd6,
    KIND_RSVD7    = 3'd7
  } kind_e;

  typedef struct packed {
    logic [TimeW-1:0] expiry;
    logic [IdW-1:0]   owner;
  } heap_entry_t;

endpackage

`default_nettype wire

### sv/tmhs_if.sv
// ----------------------------------------------------------------------------
// tmhs_in_if / tmhs_out_if
// Valid/ready channels for commands and results of the timer heap scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmhs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  timer_id;
  logic [63:0] time_value;

  modport source (output valid, opcode, timer_id, time_value, input ready);
  modport sink   (input valid, opcode, timer_id, time_value, output ready);
endinterface

interface tmhs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  expired_id;
  logic [63:0] expired_time;
  logic        last;

  modport source (output valid, kind, expired_id, expired_time, last, input ready);
  modport sink   (input valid, kind, expired_id, expired_time, last, output ready);
endinterface

`default_nettype wire

### sv/timer_min_heap_scheduler_top.sv
// ----------------------------------------------------------------------------
// timer_min_heap_scheduler_top
// Timer queue on a binary min-heap of expiry times with lazy deletion.
//
// Commands arrive on in_i (add, delete, reset, check); results leave on out_o.
// Every command gives one result with last set, except check, which gives one
// expired-timer result per reported timer (last on the final one) or a single
// none result. One command is in work at a time; in_i.ready is low meanwhile.
// The heap sits in a single-port-read memory, so sifting reads one entry at
// a time: the parent per level for add/reset, then the left and right child
// per level for check's sift-down; delete and refusals touch no heap entry.
// Results go through one output register; a stall on out_o holds the
// sequencer at its next result. Reset empties the heap and disarms every
// timer at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_min_heap_scheduler_top
  import tmhs_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 32,
  parameter int unsigned NUM_TIMERS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tmhs_in_if.sink     in_i,
  tmhs_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW = AW + 2;

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_EXEC     = 13'b0000000000010,
    ST_RESP     = 13'b0000000000100,
    ST_PUSH_TOP = 13'b0000000001000,
    ST_PUSH_CMP = 13'b0000000010000,
    ST_CHK_RD   = 13'b0000000100000,
    ST_CHK_ROOT = 13'b0000001000000,
    ST_POP_LAST = 13'b0000010000000,
    ST_SIFT_L   = 13'b0000100000000,
    ST_SIFT_R   = 13'b0001000000000,
    ST_SIFT_CMP = 13'b0010000000000,
    ST_REPORT   = 13'b0100000000000,
    ST_FIN      = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  heap_entry_t heap_mem [HEAP_DEPTH];
  logic [TimeW-1:0] dl_mem [NumIds];

  heap_entry_t      heap_rd_q;
  logic [TimeW-1:0] dl_rd_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  heap_entry_t      wdata;
  logic             dl_we;

  logic [CW-1:0]    count_q, count_d;
  logic [NumIds-1:0] armed_q, armed_d, seen_q, seen_d;
  opcode_e          op_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] tv_q;
  logic [AW-1:0]    i_q, i_d;
  logic [XW-1:0]    c_q, c_d;
  heap_entry_t      pop_q, pop_d, lt_q, lt_d, left_q, left_d;
  logic             hasr_q, hasr_d, flag_q, flag_d;
  logic [RepW-1:0]  k_q, k_d;
  logic             pend_v_q, pend_v_d;
  heap_entry_t      pend_q, pend_d;
  kind_e            rkind_q, rkind_d;

  logic             ov_q, ov_d, olast_q, olast_d;
  kind_e            okind_q, okind_d;
  logic [IdW-1:0]   oid_q, oid_d;
  logic [TimeW-1:0] otime_q, otime_d;

  logic             can_emit, id_ok, full;
  logic [AW-1:0]    parent;
  logic [XW-1:0]    c_new, n_ext;
  heap_entry_t      pick;
  logic [XW-1:0]    pick_idx;

  assign can_emit = !ov_q || out_o.ready;
  assign id_ok    = 32'(id_q) < NUM_TIMERS;
  assign full     = 32'(count_q) >= HEAP_DEPTH;
  assign parent   = AW'((i_q - AW'(1)) >> 1);
  assign c_new    = XW'({i_q, 1'b1});
  assign n_ext    = XW'(count_q);
  assign pick     = (hasr_q && (left_q.expiry > heap_rd_q.expiry)) ? heap_rd_q : left_q;
  assign pick_idx = (hasr_q && (left_q.expiry > heap_rd_q.expiry)) ? c_q + XW'(1) : c_q;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = ov_q;
  assign out_o.kind         = okind_q;
  assign out_o.expired_id   = oid_q;
  assign out_o.expired_time = otime_q;
  assign out_o.last         = olast_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    heap_rd_q <= heap_mem[raddr];
    if (dl_we) begin
      dl_mem[id_q] <= tv_q;
    end
    dl_rd_q <= dl_mem[heap_rd_q.owner];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    armed_d  = armed_q;
    seen_d   = seen_q;
    i_d      = i_q;
    c_d      = c_q;
    pop_d    = pop_q;
    lt_d     = lt_q;
    left_d   = left_q;
    hasr_d   = hasr_q;
    flag_d   = flag_q;
    k_d      = k_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    rkind_d  = rkind_q;
    ov_d     = ov_q && !out_o.ready;
    okind_d  = okind_q;
    oid_d    = oid_q;
    otime_d  = otime_q;
    olast_d  = olast_q;
    we       = 1'b0;
    waddr    = i_q;
    wdata    = lt_q;
    raddr    = '0;
    dl_we    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rkind_d = KIND_OK;
        state_d = ST_RESP;
        priority if (op_q == OP_CHECK) begin
          seen_d   = '0;
          k_d      = '0;
          pend_v_d = 1'b0;
          state_d  = ST_CHK_RD;
        end else if (op_q == OP_DELETE) begin
          if (id_ok) begin
            armed_d[id_q] = 1'b0;
          end
        end else if (op_q == OP_RESET && !(id_ok && armed_q[id_q])) begin
          rkind_d = KIND_REFUSED;
        end else if (!id_ok) begin
          rkind_d = KIND_OK;
        end else if (full) begin
          rkind_d = KIND_FULL;
        end else begin
          armed_d[id_q] = 1'b1;
          dl_we         = 1'b1;
          i_d           = AW'(count_q);
          state_d       = ST_PUSH_TOP;
        end
      end
      ST_PUSH_TOP: begin
        raddr = parent;
        if (i_q == '0) begin
          we       = 1'b1;
          wdata    = '{expiry: tv_q, owner: id_q};
          count_d  = count_q + CW'(1);
          state_d  = ST_RESP;
        end else begin
          state_d = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        we = 1'b1;
        if (tv_q < heap_rd_q.expiry) begin
          wdata   = heap_rd_q;
          i_d     = parent;
          state_d = ST_PUSH_TOP;
        end else begin
          wdata   = '{expiry: tv_q, owner: id_q};
          count_d = count_q + CW'(1);
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (can_emit) begin
          ov_d    = 1'b1;
          okind_d = rkind_q;
          oid_d   = '0;
          otime_d = '0;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CHK_RD: begin
        raddr = '0;
        if (count_q == '0 || k_q == RepW'(MaxReport)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_CHK_ROOT;
        end
      end
      ST_CHK_ROOT: begin
        raddr = AW'(count_q - CW'(1));
        if (heap_rd_q.expiry > tv_q) begin
          state_d = ST_FIN;
        end else begin
          pop_d   = heap_rd_q;
          state_d = ST_POP_LAST;
        end
      end
      ST_POP_LAST: begin
        lt_d    = heap_rd_q;
        flag_d  = armed_q[pop_q.owner] && (dl_rd_q == pop_q.expiry) && !seen_q[pop_q.owner];
        count_d = count_q - CW'(1);
        i_d     = '0;
        state_d = ST_SIFT_L;
      end
      ST_SIFT_L: begin
        c_d   = c_new;
        raddr = AW'(c_new);
        if (c_new >= n_ext) begin
          we      = 1'b1;
          wdata   = lt_q;
          state_d = ST_REPORT;
        end else begin
          state_d = ST_SIFT_R;
        end
      end
      ST_SIFT_R: begin
        left_d  = heap_rd_q;
        raddr   = AW'(c_q + XW'(1));
        hasr_d  = (c_q + XW'(1)) < n_ext;
        state_d = ST_SIFT_CMP;
      end
      ST_SIFT_CMP: begin
        we = 1'b1;
        if (lt_q.expiry > pick.expiry) begin
          wdata   = pick;
          i_d     = AW'(pick_idx);
          state_d = ST_SIFT_L;
        end else begin
          wdata   = lt_q;
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!flag_q) begin
          state_d = ST_CHK_RD;
        end else if (!pend_v_q || can_emit) begin
          if (pend_v_q) begin
            ov_d    = 1'b1;
            okind_d = KIND_EXPIRED;
            oid_d   = pend_q.owner;
            otime_d = pend_q.expiry;
            olast_d = 1'b0;
          end
          pend_v_d              = 1'b1;
          pend_d                = pop_q;
          seen_d[pop_q.owner]   = 1'b1;
          k_d                   = k_q + RepW'(1);
          state_d               = ST_CHK_RD;
        end
      end
      ST_FIN: begin
        if (can_emit) begin
          ov_d    = 1'b1;
          olast_d = 1'b1;
          if (pend_v_q) begin
            okind_d = KIND_EXPIRED;
            oid_d   = pend_q.owner;
            otime_d = pend_q.expiry;
          end else begin
            okind_d = KIND_NONE;
            oid_d   = '0;
            otime_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      armed_q  <= '0;
      seen_q   <= '0;
      k_q      <= '0;
      pend_v_q <= 1'b0;
      flag_q   <= 1'b0;
      hasr_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      armed_q  <= armed_d;
      seen_q   <= seen_d;
      k_q      <= k_d;
      pend_v_q <= pend_v_d;
      flag_q   <= flag_d;
      hasr_q   <= hasr_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      op_q <= opcode_e'(in_i.opcode);
      id_q <= in_i.timer_id;
      tv_q <= in_i.time_value;
    end
    i_q     <= i_d;
    c_q     <= c_d;
    pop_q   <= pop_d;
    lt_q    <= lt_d;
    left_q  <= left_d;
    pend_q  <= pend_d;
    rkind_q <= rkind_d;
    okind_q <= okind_d;
    oid_q   <= oid_d;
    otime_q <= otime_d;
    olast_q <= olast_d;
  end

endmodule

`default_nettype wire
